// ===== rtl/core/bgca_pkg.sv =====
// Shared types and constants for the brick gather clamped address generator.
// No dependencies; used by every module in rtl/core.
package bgca_pkg;

   // default parameter values
   localparam int MaxVolumeEdgeDef = 4096;
   localparam int MaxBrickEdgeDef  = 4;

   // field widths fixed by the interface
   localparam int CoordW  = 13;
   localparam int VolW    = 13;
   localparam int BrickW  = 3;
   localparam int AddrW   = 36;
   localparam int IndexW  = 6;
   localparam int InsideW = 7;
   localparam int CsrAddrW = 5;
   localparam int CsrDataW = 32;

   // descriptor queue between front and back
   localparam int QueueDepth = 2;

   // register indexes (paddr[4:2])
   localparam logic [2:0] RegVolumeSizeX = 3'd0;
   localparam logic [2:0] RegVolumeSizeY = 3'd1;
   localparam logic [2:0] RegVolumeSizeZ = 3'd2;
   localparam logic [2:0] RegBrickSizeX  = 3'd3;
   localparam logic [2:0] RegBrickSizeY  = 3'd4;
   localparam logic [2:0] RegBrickSizeZ  = 3'd5;

   // effective (saturated) configuration
   typedef struct packed {
      logic [VolW-1:0]   sx;
      logic [VolW-1:0]   sy;
      logic [VolW-1:0]   sz;
      logic [BrickW-1:0] bx;
      logic [BrickW-1:0] by;
      logic [BrickW-1:0] bz;
   } cfg_type;

   // one classified brick request
   typedef struct packed {
      logic signed [CoordW-1:0] ox;
      logic signed [CoordW-1:0] oy;
      logic signed [CoordW-1:0] oz;
      logic [InsideW-1:0]       in_bounds;
   } desc_type;

endpackage

// ===== rtl/core/bgca_front.sv =====
// Front part: accepts brick requests and works out the inside voxel count.
// Depends on bgca_pkg; feeds bgca_queue.
module bgca_front (
   input  bgca_pkg::cfg_type                  cfg,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [bgca_pkg::CoordW-1:0] req_origin_x,
   input  logic signed [bgca_pkg::CoordW-1:0] req_origin_y,
   input  logic signed [bgca_pkg::CoordW-1:0] req_origin_z,
   input  logic                               q_full,
   output logic                               q_push,
   output bgca_pkg::desc_type                 q_desc
);

   // voxels of one axis inside [0, size)
   function automatic logic [2:0] axis_inside(
      input logic signed [bgca_pkg::CoordW-1:0] o,
      input logic [bgca_pkg::BrickW-1:0]        e,
      input logic [bgca_pkg::VolW-1:0]          s
   );
      logic signed [14:0] ow;
      logic signed [14:0] oe;
      logic signed [14:0] sw;
      logic signed [14:0] lo;
      logic signed [14:0] hi;
      logic signed [14:0] diff;
      ow   = 15'(o);
      oe   = ow + $signed({12'b0, e});
      sw   = $signed({2'b0, s});
      lo   = (ow > 15'sd0) ? ow : 15'sd0;
      hi   = (oe < sw) ? oe : sw;
      diff = hi - lo;
      return (hi > lo) ? diff[2:0] : 3'd0;
   endfunction

   logic [2:0] ix;
   logic [2:0] iy;
   logic [2:0] iz;
   logic [5:0] pxy;

   always_comb begin
      ix  = axis_inside(req_origin_x, cfg.bx, cfg.sx);
      iy  = axis_inside(req_origin_y, cfg.by, cfg.sy);
      iz  = axis_inside(req_origin_z, cfg.bz, cfg.sz);
      pxy = {3'b0, ix} * {3'b0, iy};
      q_desc.ox        = req_origin_x;
      q_desc.oy        = req_origin_y;
      q_desc.oz        = req_origin_z;
      q_desc.in_bounds = {1'b0, pxy} * {4'b0, iz};
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// ===== rtl/core/bgca_queue.sv =====
// Short descriptor queue that decouples the front from the back.
// Depends on bgca_pkg.
module bgca_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bgca_pkg::desc_type push_desc,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output bgca_pkg::desc_type pop_desc
);

   localparam int PtrW = (bgca_pkg::QueueDepth > 1) ? $clog2(bgca_pkg::QueueDepth) : 1;
   localparam int CntW = $clog2(bgca_pkg::QueueDepth + 1);

   bgca_pkg::desc_type entry_ff [bgca_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
      return (p == PtrW'(bgca_pkg::QueueDepth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign full      = (count_ff == CntW'(bgca_pkg::QueueDepth));
   assign pop_valid = (count_ff != '0);
   assign pop_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== rtl/core/bgca_back.sv =====
// Back part: walks the brick voxels and computes clamped linear addresses.
// Depends on bgca_pkg; takes descriptors from bgca_queue.
module bgca_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bgca_pkg::cfg_type                    cfg,
   input  logic                                 q_valid,
   input  bgca_pkg::desc_type                   q_desc,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bgca_pkg::AddrW-1:0]           rsp_volume_address,
   output logic [bgca_pkg::IndexW-1:0]          rsp_brick_index,
   output logic [bgca_pkg::InsideW-1:0]         rsp_in_bounds_count,
   output logic                                 rsp_last_of_brick
);

   typedef struct packed {
      logic [bgca_pkg::VolW-1:0]    cx;
      logic [bgca_pkg::VolW-1:0]    cy;
      logic [bgca_pkg::VolW-1:0]    cz;
      logic [bgca_pkg::IndexW-1:0]  k;
      logic [bgca_pkg::InsideW-1:0] in_bounds;
      logic                         last;
   } s1_type;

   typedef struct packed {
      logic [bgca_pkg::VolW-1:0]    cx;
      logic [26:0]                  t;
      logic [bgca_pkg::IndexW-1:0]  k;
      logic [bgca_pkg::InsideW-1:0] in_bounds;
      logic                         last;
   } s2_type;

   function automatic logic [bgca_pkg::VolW-1:0] clamp(
      input logic signed [bgca_pkg::CoordW-1:0] o,
      input logic [1:0]                         d,
      input logic [bgca_pkg::VolW-1:0]          s
   );
      logic signed [13:0] v;
      v = 14'(o) + $signed({12'b0, d});
      if (v < 14'sd0) begin
         return '0;
      end else if (v >= $signed({1'b0, s})) begin
         return s - 13'd1;
      end
      return v[12:0];
   endfunction

   // sequencer
   logic               busy_ff, busy_in;
   bgca_pkg::desc_type cur_ff, cur_in;
   logic [1:0]         dx_ff, dx_in;
   logic [1:0]         dy_ff, dy_in;
   logic [1:0]         dz_ff, dz_in;
   logic [bgca_pkg::IndexW-1:0] k_ff, k_in;
   // pipeline
   logic   s1_valid_ff, s1_valid_in;
   s1_type s1_ff, s1_in;
   logic   s2_valid_ff, s2_valid_in;
   s2_type s2_ff, s2_in;
   logic   out_valid_ff, out_valid_in;
   logic [bgca_pkg::AddrW-1:0]   out_addr_ff, out_addr_in;
   logic [bgca_pkg::IndexW-1:0]  out_k_ff, out_k_in;
   logic [bgca_pkg::InsideW-1:0] out_inside_ff, out_inside_in;
   logic                         out_last_ff, out_last_in;

   logic        en;
   logic        issue;
   logic        end_x, end_y, end_z;
   logic        last0;
   logic        load;
   logic [25:0] prod_yz;
   logic [35:0] full_addr;

   always_comb begin
      en    = !out_valid_ff || !rsp_stall;
      issue = busy_ff && en;
      end_x = ({1'b0, dx_ff} == cfg.bx - 3'd1);
      end_y = ({1'b0, dy_ff} == cfg.by - 3'd1);
      end_z = ({1'b0, dz_ff} == cfg.bz - 3'd1);
      last0 = end_x && end_y && end_z;
      load  = q_valid && (!busy_ff || (issue && last0));
      q_pop = load;

      busy_in = busy_ff;
      cur_in  = cur_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      dz_in   = dz_ff;
      k_in    = k_ff;
      if (load) begin
         busy_in = 1'b1;
         cur_in  = q_desc;
         dx_in   = '0;
         dy_in   = '0;
         dz_in   = '0;
         k_in    = '0;
      end else if (issue) begin
         if (last0) begin
            busy_in = 1'b0;
         end
         k_in = k_ff + 6'd1;
         if (!end_x) begin
            dx_in = dx_ff + 2'd1;
         end else begin
            dx_in = '0;
            if (!end_y) begin
               dy_in = dy_ff + 2'd1;
            end else begin
               dy_in = '0;
               dz_in = dz_ff + 2'd1;
            end
         end
      end
   end

   // stage 1: clamp; stage 2: cy + sy*cz; stage 3: cx + sx*t
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      out_valid_in  = out_valid_ff;
      out_addr_in   = out_addr_ff;
      out_k_in      = out_k_ff;
      out_inside_in = out_inside_ff;
      out_last_in   = out_last_ff;
      prod_yz   = {13'b0, cfg.sy} * {13'b0, s1_ff.cz};
      full_addr = {23'b0, s2_ff.cx} + ({23'b0, cfg.sx} * {9'b0, s2_ff.t});
      if (en) begin
         s1_valid_in     = busy_ff;
         s1_in.cx        = clamp(cur_ff.ox, dx_ff, cfg.sx);
         s1_in.cy        = clamp(cur_ff.oy, dy_ff, cfg.sy);
         s1_in.cz        = clamp(cur_ff.oz, dz_ff, cfg.sz);
         s1_in.k         = k_ff;
         s1_in.in_bounds = cur_ff.in_bounds;
         s1_in.last      = last0;

         s2_valid_in     = s1_valid_ff;
         s2_in.cx        = s1_ff.cx;
         s2_in.t         = {14'b0, s1_ff.cy} + {1'b0, prod_yz};
         s2_in.k         = s1_ff.k;
         s2_in.in_bounds = s1_ff.in_bounds;
         s2_in.last      = s1_ff.last;

         out_valid_in  = s2_valid_ff;
         out_addr_in   = full_addr;
         out_k_in      = s2_ff.k;
         out_inside_in = s2_ff.in_bounds;
         out_last_in   = s2_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      dz_ff         <= dz_in;
      k_ff          <= k_in;
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      out_addr_ff   <= out_addr_in;
      out_k_ff      <= out_k_in;
      out_inside_ff <= out_inside_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_volume_address  = out_addr_ff;
   assign rsp_brick_index     = out_k_ff;
   assign rsp_in_bounds_count = out_inside_ff;
   assign rsp_last_of_brick   = out_last_ff;

endmodule

// ===== rtl/core/brick_gather_clamped_addresses.sv =====
// Top level of the brick gather clamped address generator: CSR block,
// front, descriptor queue and back. Depends on bgca_pkg, bgca_front,
// bgca_queue and bgca_back.
//
// Usage:
//  - req_ channel: one beat is a brick request, the signed corner
//    (origin_x, origin_y, origin_z). Accepted when req_valid && !req_stall.
//  - rsp_ channel: one beat per brick voxel, x fastest, then y, then z.
//    Each beat carries the clamp-to-edge linear address, the voxel's index
//    in the brick, the count of voxels inside the volume and a last flag.
//  - csr_ port: APB-style, six registers at byte address 4*i (volume sizes
//    x/y/z, brick edges x/y/z). pready is tied high. Write only while idle.
//  - Throughput: one voxel beat per cycle while the receiver does not stall,
//    so a brick gives bx*by*bz beats (64 at the reset sizes); the back
//    sequencer issues one voxel per cycle when not stalled and picks up the
//    next brick on the cycle of the last voxel, so bricks follow with no gap.
//  - A request beat passes the queue, the sequencer's descriptor register,
//    the clamp stage and the y/z multiply stage, then the x multiply into
//    the output register, before its first voxel beat.
//  - A two-entry queue holds requests while the back is busy; req_stall
//    rises only when it is full.
//  - When the receiver stalls, the output register and the whole back
//    pipeline hold; the front keeps taking requests until the queue fills.
//  - Reset (synchronous) empties the queue and pipeline and loads the
//    register defaults: volume 256^3, brick 4^3.
module brick_gather_clamped_addresses #(
   parameter int MAX_VOLUME_EDGE = bgca_pkg::MaxVolumeEdgeDef,
   parameter int MAX_BRICK_EDGE  = bgca_pkg::MaxBrickEdgeDef
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [bgca_pkg::CoordW-1:0]  req_origin_x,
   input  logic signed [bgca_pkg::CoordW-1:0]  req_origin_y,
   input  logic signed [bgca_pkg::CoordW-1:0]  req_origin_z,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bgca_pkg::AddrW-1:0]          rsp_volume_address,
   output logic [bgca_pkg::IndexW-1:0]         rsp_brick_index,
   output logic [bgca_pkg::InsideW-1:0]        rsp_in_bounds_count,
   output logic                                rsp_last_of_brick,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bgca_pkg::CsrAddrW-1:0]       csr_paddr,
   input  logic [bgca_pkg::CsrDataW-1:0]       csr_pwdata,
   output logic [bgca_pkg::CsrDataW-1:0]       csr_prdata,
   output logic                                csr_pready
);

   // saturation limits; 17 bits holds the largest allowed volume edge
   localparam logic [16:0] MaxVol   = 17'(MAX_VOLUME_EDGE);
   localparam logic [2:0]  MaxBrick = 3'(MAX_BRICK_EDGE);

   // raw register values as written
   logic [bgca_pkg::VolW-1:0]   vol_x_ff, vol_x_in;
   logic [bgca_pkg::VolW-1:0]   vol_y_ff, vol_y_in;
   logic [bgca_pkg::VolW-1:0]   vol_z_ff, vol_z_in;
   logic [bgca_pkg::BrickW-1:0] brk_x_ff, brk_x_in;
   logic [bgca_pkg::BrickW-1:0] brk_y_ff, brk_y_in;
   logic [bgca_pkg::BrickW-1:0] brk_z_ff, brk_z_in;

   logic                        csr_write;
   logic [2:0]                  csr_index;
   bgca_pkg::cfg_type           cfg;

   logic                        q_push;
   logic                        q_full;
   logic                        q_pop;
   logic                        q_valid;
   bgca_pkg::desc_type          q_push_desc;
   bgca_pkg::desc_type          q_pop_desc;

   // zero is taken as 1, anything above the limit saturates
   function automatic logic [bgca_pkg::VolW-1:0] eff_volume(
      input logic [bgca_pkg::VolW-1:0] s
   );
      if (s == '0) begin
         return 13'd1;
      end else if ({4'b0, s} > MaxVol) begin
         return MaxVol[12:0];
      end
      return s;
   endfunction

   function automatic logic [bgca_pkg::BrickW-1:0] eff_brick(
      input logic [bgca_pkg::BrickW-1:0] s
   );
      if (s == '0) begin
         return 3'd1;
      end else if (s > MaxBrick) begin
         return MaxBrick;
      end
      return s;
   endfunction

   // ---------------- CSR block ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      vol_x_in = vol_x_ff;
      vol_y_in = vol_y_ff;
      vol_z_in = vol_z_ff;
      brk_x_in = brk_x_ff;
      brk_y_in = brk_y_ff;
      brk_z_in = brk_z_ff;
      if (csr_write) begin
         case (csr_index)
            bgca_pkg::RegVolumeSizeX: begin
               vol_x_in = csr_pwdata[12:0];
            end
            bgca_pkg::RegVolumeSizeY: begin
               vol_y_in = csr_pwdata[12:0];
            end
            bgca_pkg::RegVolumeSizeZ: begin
               vol_z_in = csr_pwdata[12:0];
            end
            bgca_pkg::RegBrickSizeX: begin
               brk_x_in = csr_pwdata[2:0];
            end
            bgca_pkg::RegBrickSizeY: begin
               brk_y_in = csr_pwdata[2:0];
            end
            bgca_pkg::RegBrickSizeZ: begin
               brk_z_in = csr_pwdata[2:0];
            end
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_x_ff <= 13'd256;
         vol_y_ff <= 13'd256;
         vol_z_ff <= 13'd256;
         brk_x_ff <= 3'd4;
         brk_y_ff <= 3'd4;
         brk_z_ff <= 3'd4;
      end else begin
         vol_x_ff <= vol_x_in;
         vol_y_ff <= vol_y_in;
         vol_z_ff <= vol_z_in;
         brk_x_ff <= brk_x_in;
         brk_y_ff <= brk_y_in;
         brk_z_ff <= brk_z_in;
      end
   end

   always_comb begin
      case (csr_index)
         bgca_pkg::RegVolumeSizeX: csr_prdata = {19'b0, vol_x_ff};
         bgca_pkg::RegVolumeSizeY: csr_prdata = {19'b0, vol_y_ff};
         bgca_pkg::RegVolumeSizeZ: csr_prdata = {19'b0, vol_z_ff};
         bgca_pkg::RegBrickSizeX:  csr_prdata = {29'b0, brk_x_ff};
         bgca_pkg::RegBrickSizeY:  csr_prdata = {29'b0, brk_y_ff};
         bgca_pkg::RegBrickSizeZ:  csr_prdata = {29'b0, brk_z_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // effective sizes seen by front and back
   always_comb begin
      cfg.sx = eff_volume(vol_x_ff);
      cfg.sy = eff_volume(vol_y_ff);
      cfg.sz = eff_volume(vol_z_ff);
      cfg.bx = eff_brick(brk_x_ff);
      cfg.by = eff_brick(brk_y_ff);
      cfg.bz = eff_brick(brk_z_ff);
   end

   // ---------------- datapath ----------------
   bgca_front u_front (
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_origin_z (req_origin_z),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_desc       (q_push_desc)
   );

   bgca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_desc  (q_pop_desc)
   );

   bgca_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .q_valid             (q_valid),
      .q_desc              (q_pop_desc),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_volume_address  (rsp_volume_address),
      .rsp_brick_index     (rsp_brick_index),
      .rsp_in_bounds_count (rsp_in_bounds_count),
      .rsp_last_of_brick   (rsp_last_of_brick)
   );

   // ---------------- assertions ----------------
   // in-bounds count can never exceed the largest brick
   a_inside_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_in_bounds_count <= 7'd64))
      else $error("in-bounds count above brick capacity");

   // within a brick the voxel beats come back to back with rising index
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_brick) |=>
         (rsp_valid && (rsp_brick_index == $past(rsp_brick_index) + 6'd1)))
      else $error("brick voxel sequence broken");

   // the beat after a last beat, if any, opens a new brick
   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_brick) |=>
         (!rsp_valid || (rsp_brick_index == 6'd0)))
      else $error("new brick does not start at index zero");

endmodule
